// ----- src/crcfr_pkg.sv -----
`default_nettype none
package crcfr_pkg;

  localparam logic [7:0]  START_LO = 8'hA5;
  localparam logic [7:0]  START_HI = 8'h5A;
  localparam int          HEADER_BYTES = 6;
  localparam int          CRC_BYTES = 4;
  localparam logic [2:0]  HEADER_LAST_IDX = 3'(HEADER_BYTES - 1);
  localparam logic [1:0]  CRC_LAST_IDX = 2'(CRC_BYTES - 1);
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  localparam logic [1:0] ST_MORE    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_BAD_CRC = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] frame_seq;
    logic [15:0] frame_len;
  } result_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- src/crcfr_in_reg.sv -----
`default_nettype none
module crcfr_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       take,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);
  import crcfr_pkg::*;

  // held byte leaves when the output side can load
  assign in_stall = s1_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= data_byte;
    end
  end

endmodule
`default_nettype wire

// ----- src/crcfr_parser.sv -----
`default_nettype none
module crcfr_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        fire,
  input  wire logic [7:0]  b,
  output crcfr_pkg::result_t res
);
  import crcfr_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_ARMED   = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  logic [15:0] max_payload;
  logic [2:0]  phase, phase_next;
  logic [7:0]  hs [HEADER_BYTES];
  logic [7:0]  hs_next [HEADER_BYTES];
  logic [2:0]  header_count, header_count_next;
  logic [15:0] payload_count, payload_count_next;
  logic [31:0] running_crc, running_crc_next;
  logic [1:0]  crc_byte_count, crc_byte_count_next;
  logic [31:0] received_crc, received_crc_next;

  logic [15:0] hdr_len;
  logic [15:0] new_len;
  logic [15:0] count_inc;

  assign hdr_len   = {hs[5], hs[4]};
  assign new_len   = {hs_next[5], hs_next[4]};
  assign count_inc = payload_count + 16'd1;

  always_comb begin
    phase_next          = phase;
    hs_next             = hs;
    header_count_next   = header_count;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    crc_byte_count_next = crc_byte_count;
    received_crc_next   = received_crc;
    res.status          = ST_MORE;
    res.payload_valid   = 1'b0;
    res.payload_byte    = 8'd0;
    res.payload_index   = 16'd0;

    case (phase)
      PH_HUNT: begin
        if (b == START_LO) phase_next = PH_ARMED;
      end
      PH_ARMED: begin
        if (b == START_HI) begin
          running_crc_next  = CRC_INIT;
          header_count_next = 3'd0;
          phase_next        = PH_HEADER;
        end else if (b != START_LO) begin
          phase_next = PH_HUNT;
        end
      end
      PH_HEADER: begin
        if (header_count <= HEADER_LAST_IDX) hs_next[header_count] = b;
        header_count_next = header_count + 3'd1;
        running_crc_next  = crc_byte(running_crc, b);
        if (header_count >= HEADER_LAST_IDX) begin
          header_count_next   = 3'd0;
          payload_count_next  = 16'd0;
          crc_byte_count_next = 2'd0;
          received_crc_next   = 32'd0;
          if (new_len > max_payload) begin
            phase_next = PH_HUNT;
            res.status = ST_BAD_LEN;
          end else if (new_len == 16'd0) begin
            phase_next = PH_CRC;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.payload_valid  = 1'b1;
        res.payload_byte   = b;
        res.payload_index  = payload_count;
        payload_count_next = count_inc;
        running_crc_next   = crc_byte(running_crc, b);
        if (count_inc == hdr_len) begin
          crc_byte_count_next = 2'd0;
          received_crc_next   = 32'd0;
          phase_next          = PH_CRC;
        end
      end
      PH_CRC: begin
        received_crc_next = received_crc | ({24'd0, b} << {crc_byte_count, 3'b000});
        if (crc_byte_count == CRC_LAST_IDX) begin
          res.status          = (received_crc_next == ~running_crc) ? ST_OK : ST_BAD_CRC;
          phase_next          = PH_HUNT;
          header_count_next   = 3'd0;
          payload_count_next  = 16'd0;
          crc_byte_count_next = 2'd0;
          received_crc_next   = 32'd0;
        end else begin
          crc_byte_count_next = crc_byte_count + 2'd1;
        end
      end
      default: begin
        phase_next          = PH_HUNT;
        header_count_next   = 3'd0;
        payload_count_next  = 16'd0;
        crc_byte_count_next = 2'd0;
        received_crc_next   = 32'd0;
      end
    endcase

    res.frame_type  = hs_next[0];
    res.frame_flags = hs_next[1];
    res.frame_seq   = {hs_next[3], hs_next[2]};
    res.frame_len   = new_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= MAX_PAYLOAD_RESET;
      phase          <= PH_HUNT;
      header_count   <= 3'd0;
      payload_count  <= 16'd0;
      running_crc    <= 32'd0;
      crc_byte_count <= 2'd0;
      received_crc   <= 32'd0;
      for (int i = 0; i < HEADER_BYTES; i++) hs[i] <= 8'd0;
    end else begin
      if (cfg_we) max_payload <= cfg_wdata;
      if (fire) begin
        phase          <= phase_next;
        hs             <= hs_next;
        header_count   <= header_count_next;
        payload_count  <= payload_count_next;
        running_crc    <= running_crc_next;
        crc_byte_count <= crc_byte_count_next;
        received_crc   <= received_crc_next;
      end
    end
  end

  a_index_in_len: assert property (@(posedge clk) disable iff (rst)
    fire && res.payload_valid |-> res.payload_index < hdr_len)
    else $error("payload index beyond header length");

  a_verdict_in_crc: assert property (@(posedge clk) disable iff (rst)
    fire && (res.status == ST_OK || res.status == ST_BAD_CRC) |-> phase == PH_CRC)
    else $error("crc verdict outside crc phase");

  a_bad_len_hunt: assert property (@(posedge clk) disable iff (rst)
    fire && res.status == ST_BAD_LEN |=> phase == PH_HUNT && header_count == 3'd0)
    else $error("no return to hunting after bad length");

endmodule
`default_nettype wire

// ----- src/crcfr_out_reg.sv -----
`default_nettype none
module crcfr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s1_valid,
  input  wire crcfr_pkg::result_t res,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output crcfr_pkg::result_t     out_res
);
  import crcfr_pkg::*;

  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// ----- src/crc32_frame_receiver_top.sv -----
`default_nettype none
// Byte-serial frame receiver: hunts for the start word A5 5A, gathers a 6-byte
// little-endian header (type, flags, seq, len), passes payload bytes straight out
// with their index, then checks 4 little-endian bytes of reflected CRC-32 over header
// and payload. Every accepted byte gives exactly one result transaction: status more,
// ok, bad_len (len above max_payload) or bad_crc, plus the header fields as now held.
// One byte per cycle sustained while out_stall is low; one input register and one
// result register, with the parser step and byte-wide CRC update between them.
// max_payload resets to 1024; the user must write it only while the block is idle (not enforced by the block).
module crc32_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        max_payload_wr_en,
  input  wire logic [15:0] max_payload_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             payload_valid,
  output logic [7:0]       payload_byte,
  output logic [15:0]      payload_index,
  output logic [7:0]       frame_type,
  output logic [7:0]       frame_flags,
  output logic [15:0]      frame_seq,
  output logic [15:0]      frame_len
);
  import crcfr_pkg::*;

  logic       take;
  logic       s1_valid;
  logic [7:0] s1_byte;
  result_t    res;
  result_t    out_res;

  crcfr_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .take      (take),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  crcfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (max_payload_wr_en),
    .cfg_wdata (max_payload_wr_data),
    .fire      (s1_valid && take),
    .b         (s1_byte),
    .res       (res)
  );

  crcfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign status        = out_res.status;
  assign payload_valid = out_res.payload_valid;
  assign payload_byte  = out_res.payload_byte;
  assign payload_index = out_res.payload_index;
  assign frame_type    = out_res.frame_type;
  assign frame_flags   = out_res.frame_flags;
  assign frame_seq     = out_res.frame_seq;
  assign frame_len     = out_res.frame_len;

  a_payload_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> status == ST_MORE)
    else $error("payload transaction carries a final status");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !take |=> s1_valid && $stable(s1_byte))
    else $error("held input byte lost while output stalled");

endmodule
`default_nettype wire
